### rtl/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 64;
    localparam int RANK_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic REG_ACTIVE_ENTRIES = 1'b0;
    localparam logic OP_GET             = 1'b0;
    localparam logic OP_PUT             = 1'b1;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(ENTRIES);

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_HIT,
        CMD_EVICT,
        CMD_FILL
    } cmd_mode_t;

    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] rank;
        logic [VAL_W-1:0]  value;
        logic [KEY_W-1:0]  victim_key;
        logic              free_found;
    } chain_t;

    typedef struct packed {
        cmd_mode_t         mode;
        logic              op;
        logic [RANK_W-1:0] limit;
        logic [VAL_W-1:0]  value;
    } cmd_t;

endpackage

### rtl/lkv_cell.sv
`timescale 1ns / 1ps

module lkv_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lkv_pkg::KEY_W-1:0]  req_key,
    input  logic [lkv_pkg::RANK_W-1:0] victim_rank,
    input  lkv_pkg::chain_t            chain_in,
    output lkv_pkg::chain_t            chain_out,
    input  lkv_pkg::cmd_t              cmd
);
    import lkv_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  value_next;
    logic              valid_reg;
    logic              valid_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;

    logic match;
    logic victim;
    logic first_free;
    logic target;

    assign match      = valid_reg && (key_reg == req_key);
    assign victim     = valid_reg && (rank_reg == victim_rank);
    assign first_free = !valid_reg && !chain_in.free_found;

    always_comb
    begin
        chain_out.hit        = chain_in.hit | match;
        chain_out.rank       = chain_in.rank | (match ? rank_reg : '0);
        chain_out.value      = chain_in.value | (match ? value_reg : '0);
        chain_out.victim_key = chain_in.victim_key | (victim ? key_reg : '0);
        chain_out.free_found = chain_in.free_found | !valid_reg;
    end

    always_comb
    begin
        case (cmd.mode)
            CMD_HIT:   target = match;
            CMD_EVICT: target = victim;
            CMD_FILL:  target = first_free;
            default:   target = 1'b0;
        endcase
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (target)
        begin
            rank_next = '0;
            if (cmd.mode != CMD_HIT)
            begin
                key_next = req_key;
            end
            if (cmd.op == OP_PUT)
            begin
                value_next = cmd.value;
            end
            if (cmd.mode == CMD_FILL)
            begin
                valid_next = 1'b1;
            end
        end
        else if (valid_reg && cmd.mode != CMD_NONE
                 && (cmd.mode == CMD_FILL || rank_reg < cmd.limit))
        begin
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Channel   Handshake                          Payload
// request   start, taken when busy is low      opcode, key, write_value
// result    done, one-cycle strobe             hit, read_value, evicted, evicted_key
// config    APB write, pready tied high        paddr, pwdata (active_entries)
//
// A request is first captured into registers; then, in the work state, the key
// runs down the cell chain for match, victim and free-slot search and, on a hit or
// a PUT, the cells update their ranks. done pulses in the cycle after that, while busy is low again.
// rst_n clears the valid bits, ranks and fill count; no clearing pass is needed.
// The receiver cannot stall: done is high for one cycle only; the result outputs hold until the next request completes.

module lru_key_value_cache (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic signed [lkv_pkg::KEY_W-1:0]  key,
    input  logic [lkv_pkg::VAL_W-1:0]         write_value,
    output logic                              done,
    output logic                              hit,
    output logic [lkv_pkg::VAL_W-1:0]         read_value,
    output logic                              evicted,
    output logic signed [lkv_pkg::KEY_W-1:0]  evicted_key,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::PADDR_W-1:0]       paddr,
    input  logic [lkv_pkg::DATA_W-1:0]        pwdata,
    output logic [lkv_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import lkv_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  active_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              done_reg;
    logic              done_next;
    logic              hit_reg;
    logic              hit_next;
    logic [VAL_W-1:0]  read_value_reg;
    logic [VAL_W-1:0]  read_value_next;
    logic              evicted_reg;
    logic              evicted_next;
    logic [KEY_W-1:0]  evicted_key_reg;
    logic [KEY_W-1:0]  evicted_key_next;

    chain_t            links [ENTRIES+1];
    chain_t            chain_end;
    cmd_t              cmd;
    logic [CNT_W-1:0]  cap;
    logic [RANK_W-1:0] victim_rank;
    logic              accept;
    logic              cfg_write;

    assign accept      = start && (state_reg == ST_IDLE);
    assign cfg_write   = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign busy        = (state_reg == ST_WORK);
    assign chain_end   = links[ENTRIES];
    assign victim_rank = RANK_W'(fill_count_reg - CNT_W'(1));
    assign links[0]    = '0;

    always_comb
    begin
        if (active_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (active_reg > CNT_W'(ENTRIES))
        begin
            cap = CNT_W'(ENTRIES);
        end
        else
        begin
            cap = active_reg;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ACTIVE_ENTRIES)
        begin
            prdata = DATA_W'(active_reg);
        end
    end

    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            lkv_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .req_key     (key_reg),
                .victim_rank (victim_rank),
                .chain_in    (links[i]),
                .chain_out   (links[i+1]),
                .cmd         (cmd)
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        fill_count_next  = fill_count_reg;
        done_next        = 1'b0;
        hit_next         = hit_reg;
        read_value_next  = read_value_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;
        cmd.mode         = CMD_NONE;
        cmd.op           = op_reg;
        cmd.limit        = '0;
        cmd.value        = value_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                state_next       = ST_IDLE;
                done_next        = 1'b1;
                hit_next         = chain_end.hit;
                read_value_next  = '0;
                evicted_next     = 1'b0;
                evicted_key_next = '0;
                if (chain_end.hit)
                begin
                    cmd.mode  = CMD_HIT;
                    cmd.limit = chain_end.rank;
                    if (op_reg == OP_GET)
                    begin
                        read_value_next = chain_end.value;
                    end
                end
                else if (op_reg == OP_PUT)
                begin
                    if (fill_count_reg >= cap)
                    begin
                        cmd.mode         = CMD_EVICT;
                        cmd.limit        = victim_rank;
                        evicted_next     = 1'b1;
                        evicted_key_next = chain_end.victim_key;
                    end
                    else
                    begin
                        cmd.mode        = CMD_FILL;
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            active_reg     <= ACTIVE_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            done_reg       <= done_next;
            if (cfg_write && paddr[2] == REG_ACTIVE_ENTRIES)
            begin
                active_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            key_reg   <= key;
            value_reg <= write_value;
        end
        hit_reg         <= hit_next;
        read_value_reg  <= read_value_next;
        evicted_reg     <= evicted_next;
        evicted_key_reg <= evicted_key_next;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule

### sim/lru_cache_checker.sv
`timescale 1ns / 1ps

module lru_cache_checker
    import lkv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     opcode,
    input  logic signed [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]         write_value,
    input  logic                     done,
    input  logic                     hit,
    input  logic [VAL_W-1:0]         read_value,
    input  logic                     evicted,
    input  logic signed [KEY_W-1:0]  evicted_key,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]        pwdata,
    input  logic                     pready,
    output int                       outstanding,
    output int                       mismatches
);

    localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE_ENTRIES, 2'b00};

    typedef struct packed {
        logic                    hit;
        logic [VAL_W-1:0]        read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } cache_resp_t;

    logic [KEY_W-1:0] slot_key   [ENTRIES];
    logic [VAL_W-1:0] slot_value [ENTRIES];
    bit               slot_valid [ENTRIES];
    int               slot_age   [ENTRIES];
    int               slot_count;
    logic [4:0]       capacity;

    cache_resp_t      pending_responses[$];
    int               fail_total;

    task automatic make_recent(input int s, input int limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != s && slot_valid[i] && slot_age[i] < limit)
                slot_age[i]++;
        end
        slot_age[s] = 0;
    endtask

    task automatic cache_response(input logic op, input logic [KEY_W-1:0] k,
                                  input logic [VAL_W-1:0] v, output cache_resp_t r);
        int  slot;
        int  cap_eff;
        int  worst;
        bit  found;
        bit  any;
        r = '0;
        slot = 0;
        found = 0;
        cap_eff = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && slot_valid[i] && slot_key[i] == k) begin
                slot = i;
                found = 1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (op == OP_GET)
                r.read_value = slot_value[slot];
            else
                slot_value[slot] = v;
            make_recent(slot, slot_age[slot]);
            return;
        end
        if (op == OP_GET)
            return;
        if (slot_count >= cap_eff) begin
            any = 0;
            worst = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i] && (!any || slot_age[i] > worst)) begin
                    worst = slot_age[i];
                    slot = i;
                    any = 1;
                end
            end
            if (any) begin
                r.evicted = 1'b1;
                r.evicted_key = slot_key[slot];
                slot_key[slot] = k;
                slot_value[slot] = v;
                make_recent(slot, slot_age[slot]);
                return;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) begin
                slot_valid[i] = 1;
                slot_key[i] = k;
                slot_value[i] = v;
                make_recent(i, ENTRIES + 1);
                slot_count++;
                return;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        cache_resp_t want;
        cache_resp_t got;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 0;
                slot_age[i] = 0;
            end
            slot_count = 0;
            capacity = ACTIVE_RESET[4:0];
            pending_responses.delete();
            fail_total = 0;
            outstanding <= 0;
            mismatches <= 0;
        end
        else begin
            if (done) begin
                if (pending_responses.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_total++;
                end
                else begin
                    want = pending_responses.pop_front();
                    got = '{hit, read_value, evicted, evicted_key};
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        fail_total++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, got.read_value);
                        fail_total++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
                        fail_total++;
                    end
                    if (got.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %0d, actual %0d",
                               want.evicted_key, got.evicted_key);
                        fail_total++;
                    end
                end
            end
            if (start && !busy) begin
                cache_response(opcode, key, write_value, want);
                pending_responses.push_back(want);
            end
            if (psel && penable && pwrite && pready && paddr == ACTIVE_ADDR)
                capacity = pwdata[4:0];
            outstanding <= pending_responses.size();
            mismatches <= fail_total;
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import lkv_pkg::*;

    localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE_ENTRIES, 2'b00};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_NEG1 = '1;
    localparam logic [VAL_W-1:0] VAL_ONES = '1;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 135;
    localparam int IDLE_LIMIT = 2000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    opcode = OP_GET;
    logic signed [KEY_W-1:0] key = '0;
    logic [VAL_W-1:0]        write_value = '0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;

    logic                    busy;
    logic                    done;
    logic                    hit;
    logic [VAL_W-1:0]        read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int                      outstanding;
    int                      mismatches;
    int                      idle_cycles = 0;
    int                      burst_left = 0;
    int                      pool_size;
    logic signed [KEY_W-1:0] key_pool [32];
    logic [4:0]              phase_caps [PHASES];

    always #5 clk = ~clk;

    lru_key_value_cache u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key         (key),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lru_cache_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key         (key),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic issue_request(input logic op, input logic signed [KEY_W-1:0] k,
                                 input logic [VAL_W-1:0] v);
        if (burst_left == 0) begin
            if (start) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        start <= 1'b1;
        opcode <= op;
        key <= k;
        write_value <= v;
        do @(posedge clk); while (busy);
        burst_left--;
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ACTIVE_ADDR;
        pwdata <= {(DATA_W-5)'($urandom), cap};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic refill_key_pool(input logic [4:0] cap);
        int eff;
        eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
        pool_size = eff + $urandom_range(1, 8);
        for (int i = 0; i < 32; i++)
            key_pool[i] = $urandom;
        if ($urandom_range(0, 1)) key_pool[0] = KEY_MIN;
        if ($urandom_range(0, 1)) key_pool[1] = KEY_MAX;
        key_pool[2] = KEY_NEG1;
        if ($urandom_range(0, 1)) key_pool[3] = '0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VAL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic signed [KEY_W-1:0] k;
        phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd8, 5'd0,
                       5'd17, 5'd3, 5'd16, 5'd12, 5'd1, 5'd16};
        phase_caps[PHASES-1] = 5'($urandom_range(0, 31));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(OP_GET, '0, VAL_ONES);
        issue_request(OP_PUT, KEY_MIN, VAL_ONES);
        issue_request(OP_PUT, KEY_MAX, '0);
        issue_request(OP_PUT, KEY_NEG1, 64'h0123_4567_89ab_cdef);
        issue_request(OP_PUT, '0, 64'h8000_0000_0000_0001);
        issue_request(OP_GET, KEY_MIN, '0);
        issue_request(OP_GET, KEY_MAX, VAL_ONES);
        issue_request(OP_GET, KEY_NEG1, '0);
        issue_request(OP_PUT, KEY_MAX, 64'ha5a5_5a5a_f00f_0ff0);
        issue_request(OP_GET, KEY_MAX, '0);
        issue_request(OP_GET, 32'sd12345, '0);
        // drop capacity to zero below the fill count
        write_capacity(5'd0);
        issue_request(OP_PUT, 32'sd77, 64'd77);
        issue_request(OP_PUT, 32'sd78, 64'd78);
        issue_request(OP_GET, 32'sd77, '0);
        issue_request(OP_GET, KEY_NEG1, '0);
        write_capacity(5'd31);
        issue_request(OP_PUT, 32'sd99, 64'd99);
        issue_request(OP_GET, 32'sd99, '0);
        write_capacity(5'd1);
        issue_request(OP_PUT, KEY_NEG1, 64'd1);
        issue_request(OP_PUT, KEY_MIN, 64'd2);
        issue_request(OP_GET, KEY_NEG1, '0);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p]);
            refill_key_pool(phase_caps[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                                : key_pool[$urandom_range(0, pool_size - 1)];
                issue_request(logic'($urandom_range(0, 1)), k, pick_value());
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
